/* src/pva_pkg.sv */
package pva_pkg;

  // command codes on the request channel
  localparam logic [1:0] CMD_ON   = 2'd0;
  localparam logic [1:0] CMD_OFF  = 2'd1;
  localparam logic [1:0] CMD_DONE = 2'd2;

  localparam int unsigned NumSlotsDef = 32;
  // slot index width that covers the largest supported slot count (64)
  localparam int unsigned MaxIdxW     = 6;
  localparam int unsigned MaskW       = 32;
  localparam int unsigned NoteW       = 7;
  localparam int unsigned DoneW       = 5;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_ON,
    KIND_OFF,
    KIND_DONE
  } pva_kind_e;

  // request token that walks down the row of slot cells
  typedef struct packed {
    logic               valid;
    pva_kind_e          kind;
    logic [NoteW-1:0]   note;
    logic [DoneW-1:0]   done_slot;
    logic               free_found;
    logic [MaxIdxW-1:0] free_pick;
    logic               rel_found;
    logic [MaxIdxW-1:0] rel_pick;
    logic               hit;
    logic [MaskW-1:0]   rel_mask;
  } pva_token_t;

  // slot write broadcast when a new voice is placed
  typedef struct packed {
    logic               valid;
    logic [MaxIdxW-1:0] slot;
    logic [NoteW-1:0]   note;
  } pva_commit_t;

endpackage

/* src/polyphonic_voice_allocator.sv */
// polyphonic voice allocator with voice stealing
//
// request channel: in_valid_i / in_ready_o with command_i, note_i,
// velocity_i and done_slot_i. every request gives exactly one result on
// out_valid_o / out_ready_i: release_mask_o, assigned_o, assigned_slot_o
// and stolen_o.
// one request is in flight at a time. the request walks down a row of
// NUM_SLOTS slot cells, one cell per cycle, then waits in the tail
// register where the new voice is written back, until the result register
// is free. the result and the input's ready both come up in the cycle
// after the request retires from the tail.
// the result register lets the next request enter while the receiver
// stalls; a request that reaches the tail while a result is still
// waiting holds there until the result is taken.
// reset clears every slot to free and not releasing; note numbers are
// not cleared and are only read for occupied slots.
module polyphonic_voice_allocator
  import pva_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [NoteW-1:0]    note_i,
  input  logic [NoteW-1:0]    velocity_i,
  input  logic [DoneW-1:0]    done_slot_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MaskW-1:0]    release_mask_o,
  output logic                assigned_o,
  output logic [DoneW-1:0]    assigned_slot_o,
  output logic                stolen_o
);

  // token chain: tok[0] is the incoming request, tok[i+1] leaves cell i
  pva_token_t  tok [NUM_SLOTS+1];
  pva_commit_t commit;

  logic        active_q;
  logic        in_fire;
  pva_token_t  tail_q;
  logic        fire;

  logic               out_valid_q;
  logic [MaskW-1:0]   mask_q;
  logic               assigned_q;
  logic [DoneW-1:0]   aslot_q;
  logic               stolen_q;
  logic [MaxIdxW-1:0] pick;

  assign in_ready_o = !active_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // build the request token
  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = in_fire;
    tok[0].note       = note_i;
    tok[0].done_slot  = done_slot_i;
    unique case (command_i)
      CMD_ON:   tok[0].kind = (velocity_i != '0) ? KIND_ON : KIND_OFF;
      CMD_OFF:  tok[0].kind = KIND_OFF;
      CMD_DONE: tok[0].kind = KIND_DONE;
      default:  tok[0].kind = KIND_NOP;
    endcase
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    pva_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .commit_i (commit),
      .tok_o    (tok[g+1])
    );
  end

  // retire the request once the result register is free
  assign fire = tail_q.valid && (!out_valid_q || out_ready_i);

  // lowest free slot, else lowest releasing slot, else slot 0
  always_comb begin
    if (tail_q.free_found) pick = tail_q.free_pick;
    else if (tail_q.rel_found) pick = tail_q.rel_pick;
    else pick = '0;
  end

  // write the new voice into its slot
  always_comb begin
    commit.valid = fire && (tail_q.kind == KIND_ON);
    commit.slot  = pick;
    commit.note  = tail_q.note;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      tail_q.valid <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) active_q <= 1'b1;
      else if (fire) active_q <= 1'b0;
      if (tok[NUM_SLOTS].valid) tail_q <= tok[NUM_SLOTS];
      else if (fire) tail_q.valid <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      mask_q <= tail_q.rel_mask;
      if (tail_q.kind == KIND_ON) begin
        assigned_q <= 1'b1;
        aslot_q    <= pick[DoneW-1:0];
        // no free slot means the picked slot held a voice
        stolen_q   <= !tail_q.free_found;
      end else begin
        assigned_q <= 1'b0;
        aslot_q    <= '0;
        stolen_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign release_mask_o  = mask_q;
  assign assigned_o      = assigned_q;
  assign assigned_slot_o = aslot_q;
  assign stolen_o        = stolen_q;

  // a taken request blocks the input until it retires
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // the token leaves the row only for a request in flight
  a_token_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NUM_SLOTS].valid |-> (active_q && !tail_q.valid))
    else $error("stray token at the end of the cell row");

  // a result without a new voice carries no slot and no steal
  a_unassigned_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !assigned_o) |-> (!stolen_o && (assigned_slot_o == '0)))
    else $error("slot fields set without an assignment");

  // a retiring request frees the input in the next cycle
  a_retire_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (in_ready_o && out_valid_o))
    else $error("retire did not free the input or load the result");

endmodule

/* src/pva_cell.sv */
module pva_cell
  import pva_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pva_token_t  tok_i,
  input  pva_commit_t commit_i,
  output pva_token_t  tok_o
);

  localparam logic [MaxIdxW-1:0] IdxV    = MaxIdxW'(Idx);
  localparam bit                 ShowBit = (Idx < MaskW);
  localparam int unsigned        BitPos  = Idx % MaskW;

  logic             busy_q, busy_d;
  logic             rel_q, rel_d;
  logic [NoteW-1:0] note_q, note_d;
  pva_token_t       tok_q, tok_d;
  logic             match;

  assign match = busy_q && !rel_q && (note_q == tok_i.note);

  always_comb begin
    busy_d = busy_q;
    rel_d  = rel_q;
    note_d = note_q;
    tok_d  = tok_i;
    if (tok_i.valid) begin
      case (tok_i.kind)
        KIND_ON: begin
          if (match) begin
            rel_d = 1'b1;
            if (ShowBit) tok_d.rel_mask[BitPos] = 1'b1;
          end
          if (!busy_q && !tok_i.free_found) begin
            tok_d.free_found = 1'b1;
            tok_d.free_pick  = IdxV;
          end
          // a slot released just now counts as releasing
          if (busy_q && (rel_q || match) && !tok_i.rel_found) begin
            tok_d.rel_found = 1'b1;
            tok_d.rel_pick  = IdxV;
          end
        end
        KIND_OFF: begin
          if (match && !tok_i.hit) begin
            rel_d     = 1'b1;
            tok_d.hit = 1'b1;
            if (ShowBit) tok_d.rel_mask[BitPos] = 1'b1;
          end
        end
        KIND_DONE: begin
          if (MaxIdxW'(tok_i.done_slot) == IdxV) begin
            busy_d = 1'b0;
            rel_d  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (commit_i.valid && (commit_i.slot == IdxV)) begin
      busy_d = 1'b1;
      rel_d  = 1'b0;
      note_d = commit_i.note;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rel_q       <= 1'b0;
      tok_q.valid <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rel_q  <= rel_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
  end

  assign tok_o = tok_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb
  import pva_pkg::*;
;

  localparam int NUM_SLOTS = NumSlotsDef;
  // command 3 has no meaning, the block must answer zeros and change nothing
  localparam logic [1:0] CMD_NOP = 2'd3;
  // notes kept in a narrow band so that note-offs and retriggers find matches
  localparam int KEY_BASE = 60;
  localparam int KEY_SPAN = 8;

  typedef struct packed {
    logic [MaskW-1:0] release_mask;
    logic             assigned;
    logic [DoneW-1:0] slot;
    logic             stolen;
  } voice_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       command_i = CMD_ON;
  logic [NoteW-1:0] note_i = '0;
  logic [NoteW-1:0] velocity_i = '0;
  logic [DoneW-1:0] done_slot_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [MaskW-1:0] release_mask_o;
  logic             assigned_o;
  logic [DoneW-1:0] assigned_slot_o;
  logic             stolen_o;

  // slot table as the bench sees it
  logic             slot_on [NUM_SLOTS];
  logic [NoteW-1:0] slot_key [NUM_SLOTS];
  logic             slot_fading [NUM_SLOTS];

  voice_result_t pending_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long receiver hold-off, handed to the receiver process which counts it down
  int stall_request = 0;
  int stall_left = 0;

  polyphonic_voice_allocator #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .note_i         (note_i),
    .velocity_i     (velocity_i),
    .done_slot_i    (done_slot_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .release_mask_o (release_mask_o),
    .assigned_o     (assigned_o),
    .assigned_slot_o(assigned_slot_o),
    .stolen_o       (stolen_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // apply one event to the slot table and return the result it should give
  function automatic voice_result_t voice_table_apply(input logic [1:0] cmd,
      input logic [NoteW-1:0] key, input logic [NoteW-1:0] vel,
      input logic [DoneW-1:0] done);
    voice_result_t res;
    int pick;
    bit found;
    res = '0;
    pick = 0;
    found = 1'b0;
    if (cmd == CMD_ON && vel != '0) begin
      // retrigger: every sounding voice on this note goes into release
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_on[i] && !slot_fading[i] && slot_key[i] == key) begin
          slot_fading[i] = 1'b1;
          if (i < MaskW) res.release_mask[i] = 1'b1;
        end
      end
      // lowest free slot, then lowest releasing slot, else slot 0 is stolen
      for (int i = 0; i < NUM_SLOTS && !found; i++) begin
        if (!slot_on[i]) begin
          pick = i;
          found = 1'b1;
        end
      end
      for (int i = 0; i < NUM_SLOTS && !found; i++) begin
        if (slot_on[i] && slot_fading[i]) begin
          pick = i;
          found = 1'b1;
        end
      end
      res.stolen = slot_on[pick];
      res.assigned = 1'b1;
      res.slot = pick[DoneW-1:0];
      slot_on[pick] = 1'b1;
      slot_key[pick] = key;
      slot_fading[pick] = 1'b0;
    end else if (cmd == CMD_ON || cmd == CMD_OFF) begin
      // note-off releases only the lowest matching voice
      for (int i = 0; i < NUM_SLOTS && !found; i++) begin
        if (slot_on[i] && !slot_fading[i] && slot_key[i] == key) begin
          slot_fading[i] = 1'b1;
          if (i < MaskW) res.release_mask[i] = 1'b1;
          found = 1'b1;
        end
      end
    end else if (cmd == CMD_DONE) begin
      if (done < NUM_SLOTS) begin
        slot_on[done] = 1'b0;
        slot_fading[done] = 1'b0;
      end
    end
    return res;
  endfunction

  // entered and left at a falling edge; the model is updated on acceptance
  task automatic send_request(input logic [1:0] cmd, input logic [NoteW-1:0] key,
      input logic [NoteW-1:0] vel, input logic [DoneW-1:0] done);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    note_i      <= key;
    velocity_i  <= vel;
    done_slot_i <= done;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(voice_table_apply(cmd, key, vel, done));
    @(negedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [MaskW-1:0] want,
      input logic [MaskW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // every result taken is held against the oldest expectation
  always @(posedge clk_i) begin : result_check
    voice_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual mask %h slot %0d",
                 $time, release_mask_o, assigned_slot_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        report_field("release_mask", want.release_mask, release_mask_o);
        report_field("assigned", MaskW'(want.assigned), MaskW'(assigned_o));
        report_field("assigned_slot", MaskW'(want.slot), MaskW'(assigned_slot_o));
        report_field("stolen", MaskW'(want.stolen), MaskW'(stolen_o));
      end
    end
  end

  // receiver: random stalls, or a long counted hold-off when one is asked for
  always @(negedge clk_i) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // free every sounding slot so a test starts from an empty table
  task automatic clear_table();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_on[i]) send_request(CMD_DONE, 7'($urandom), 7'($urandom), i[DoneW-1:0]);
    end
  endtask

  // field extremes, every command and the simple corner cases
  task automatic test_basic_events();
    send_request(CMD_ON, 7'd0, 7'd127, 5'd31);    // first voice into slot 0
    send_request(CMD_ON, 7'd127, 7'd1, 5'd0);     // slot 1
    send_request(CMD_ON, 7'd0, 7'd64, 5'd21);     // retrigger: slot 0 released, slot 2 taken
    send_request(CMD_OFF, 7'd127, 7'd0, 5'd10);   // release slot 1
    send_request(CMD_OFF, 7'd127, 7'd127, 5'd31); // note-off with no match
    send_request(CMD_ON, 7'd0, 7'd0, 5'd0);       // zero velocity acts as note-off
    send_request(CMD_NOP, 7'd85, 7'd42, 5'd21);   // unknown command
    send_request(CMD_DONE, 7'd127, 7'd127, 5'd31); // finished slot already free
    send_request(CMD_ON, 7'd85, 7'd42, 5'd10);    // slot 3
    send_request(CMD_ON, 7'd42, 7'd85, 5'd0);     // slot 4
    send_request(CMD_DONE, 7'd0, 7'd0, 5'd0);     // free slot 0
    send_request(CMD_ON, 7'd85, 7'd127, 5'd31);   // retrigger 85, reuses free slot 0
    send_request(CMD_OFF, 7'd42, 7'd42, 5'd21);
    send_request(CMD_OFF, 7'd85, 7'd1, 5'd10);
    send_request(CMD_DONE, 7'd0, 7'd0, 5'd1);
    send_request(CMD_DONE, 7'd0, 7'd0, 5'd2);
  endtask

  // full table: stealing, release and reuse in one event, releasing slot pick
  task automatic test_full_table();
    clear_table();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_request(CMD_ON, 7'(10 + i), 7'($urandom_range(1, 127)), 5'($urandom));
    end
    send_request(CMD_ON, 7'd100, 7'd90, 5'd0);    // nothing free or fading: steal slot 0
    send_request(CMD_ON, 7'd15, 7'd90, 5'd0);     // slot 5 released and taken back at once
    send_request(CMD_OFF, 7'd20, 7'd0, 5'd0);     // slot 10 fading
    send_request(CMD_OFF, 7'd30, 7'd0, 5'd0);     // slot 20 fading
    send_request(CMD_ON, 7'd101, 7'd90, 5'd0);    // lowest fading slot 10 is cut
    send_request(CMD_DONE, 7'd0, 7'd0, 5'd20);
    send_request(CMD_ON, 7'd102, 7'd90, 5'd0);    // free slot 20 wins over nothing
    clear_table();
  endtask

  // random events, biased to what the table holds so deep states are reached
  task automatic test_random_traffic(input int count, input int snd_pct,
      input int rcv_pct);
    logic [1:0]       cmd;
    logic [NoteW-1:0] key;
    logic [NoteW-1:0] vel;
    logic [DoneW-1:0] done;
    int               pick_kind;
    logic [NoteW-1:0] sounding[$];
    int               busy_slots[$];
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) begin
      sounding.delete();
      busy_slots.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_on[i]) busy_slots.push_back(i);
        if (slot_on[i] && !slot_fading[i]) sounding.push_back(slot_key[i]);
      end
      key  = 7'($urandom);
      vel  = 7'($urandom);
      done = 5'($urandom);
      pick_kind = $urandom_range(99);
      if (pick_kind < 75) begin
        if (pick_kind < 50) begin
          cmd = CMD_ON;
          vel = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
        end else begin
          cmd = CMD_OFF;
        end
        case ($urandom_range(9))
          0, 1: ;  // any note
          2, 3, 4: if (sounding.size() != 0)
            key = sounding[$urandom_range(sounding.size() - 1)];
          default: key = 7'(KEY_BASE + $urandom_range(KEY_SPAN - 1));
        endcase
      end else if (pick_kind < 95) begin
        cmd = CMD_DONE;
        if (busy_slots.size() != 0 && $urandom_range(4) != 0)
          done = 5'(busy_slots[$urandom_range(busy_slots.size() - 1)]);
      end else begin
        cmd = CMD_NOP;
      end
      send_request(cmd, key, vel, done);
    end
  endtask

  // receiver holds off for a long time while requests keep coming, so the
  // result register and the tail fill up and the input stalls
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 400;
    for (int i = 0; i < 10; i++) begin
      send_request((i % 3 == 2) ? CMD_OFF : CMD_ON, 7'(KEY_BASE + i % KEY_SPAN),
                   7'($urandom_range(1, 127)), 5'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_on[i] = 1'b0;
      slot_fading[i] = 1'b0;
      slot_key[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_events();
    test_full_table();
    test_random_traffic(170, 26, 87);
    test_random_traffic(170, 87, 26);
    test_random_traffic(170, 0, 0);
    test_output_stall();
    in_valid_i <= 1'b0;

    // drain, then give the block one more pass time to show stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
